>>> hdl/sdn_pkg.sv
// Shared constants and helpers for the stick deadzone normaliser.
// No dependencies; imported by the divider and the top level.
package sdn_pkg;

  localparam int FRAC       = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam int DZ_W       = 15;
  localparam int THR_W      = 10;
  localparam int FS_W       = 15;

  localparam logic [15:0] OUT_LIMIT = 16'h7FFF;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_RADIAL = 2'd1,
    KIND_AXIAL  = 2'd2
  } kind_t;

  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_DZ  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_DZ = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AX_THR   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_AX_FS    = 2'd3;

  localparam logic [DZ_W-1:0]  LEFT_DZ_RST  = 15'd7849;
  localparam logic [DZ_W-1:0]  RIGHT_DZ_RST = 15'd8689;
  localparam logic [THR_W-1:0] AX_THR_RST   = 10'd200;
  localparam logic [FS_W-1:0]  AX_FS_RST    = 15'd1000;

  // saturate and apply sign to a quotient
  function automatic logic [15:0] sat_pack(input logic neg, input logic sat,
                                           input logic [FRAC-1:0] q);
    logic [15:0] m;
    m = sat ? OUT_LIMIT : {1'b0, q};
    sat_pack = neg ? (~m + 16'd1) : m;
  endfunction

endpackage

>>> hdl/sdn_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// No package dependency; side data travels alongside each request.
module sdn_isqrt #(
  parameter int AB   = 16,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*AB-1:0]   in_rad,
  input  logic [SB_W-1:0]   in_side,
  output logic              out_valid,
  output logic [AB-1:0]     out_root,
  output logic [SB_W-1:0]   out_side
);

  logic              vld  [AB];
  logic [AB:0]       rem  [AB];
  logic [AB-1:0]     root [AB];
  logic [2*AB-1:0]   rad  [AB];
  logic [SB_W-1:0]   side [AB];

  for (genvar s = 0; s < AB; s++) begin : g_stage
    logic            vld_in;
    logic [AB:0]     rem_in;
    logic [AB-1:0]   root_in;
    logic [2*AB-1:0] rad_in;
    logic [SB_W-1:0] side_in;
    logic [AB+2:0]   rem_sh;
    logic [AB+2:0]   trial;
    logic [AB+2:0]   rem_nx;
    logic            ge;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[s-1];
      assign rem_in  = rem[s-1];
      assign root_in = root[s-1];
      assign rad_in  = rad[s-1];
      assign side_in = side[s-1];
    end

    assign rem_sh = {rem_in, rad_in[2*AB-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;
    assign rem_nx = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= rem_nx[AB:0];
        root[s] <= {root_in[AB-2:0], ge};
        rad[s]  <= {rad_in[2*AB-3:0], 2'b00};
        side[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[AB-1];
  assign out_root  = root[AB-1];
  assign out_side  = side[AB-1];

endmodule

>>> hdl/sdn_div.sv
// Pipelined restoring divider with overflow flag, one quotient bit per stage.
// Depends on sdn_pkg for the quotient width.
module sdn_div #(
  parameter int NW   = 46,
  parameter int DW   = 30,
  parameter int SB_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [NW-1:0]             in_num,
  input  logic [DW-1:0]             in_den,
  input  logic [SB_W-1:0]           in_side,
  output logic                      out_valid,
  output logic [sdn_pkg::FRAC-1:0]  out_quot,
  output logic                      out_sat,
  output logic [SB_W-1:0]           out_side
);
  import sdn_pkg::*;

  localparam int CW = (NW > DW + FRAC) ? NW : DW + FRAC;

  logic            v0;
  logic [CW-1:0]   rem0;
  logic [DW-1:0]   den0;
  logic            sat0;
  logic [SB_W-1:0] side0;

  logic            vld  [FRAC];
  logic [CW-1:0]   rem  [FRAC];
  logic [DW-1:0]   den  [FRAC];
  logic [FRAC-1:0] quot [FRAC];
  logic            sat  [FRAC];
  logic [SB_W-1:0] side [FRAC];

  // quotient of 2^FRAC or more saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0  <= CW'(in_num);
      den0  <= in_den;
      sat0  <= CW'(in_num) >= (CW'(in_den) << FRAC);
      side0 <= in_side;
    end
  end

  for (genvar j = 0; j < FRAC; j++) begin : g_stage
    logic            vld_in;
    logic [CW-1:0]   rem_in;
    logic [DW-1:0]   den_in;
    logic [FRAC-1:0] quot_in;
    logic            sat_in;
    logic [SB_W-1:0] side_in;
    logic [CW-1:0]   trial;
    logic            ge;

    if (j == 0) begin : g_first
      assign vld_in  = v0;
      assign rem_in  = rem0;
      assign den_in  = den0;
      assign quot_in = '0;
      assign sat_in  = sat0;
      assign side_in = side0;
    end else begin : g_next
      assign vld_in  = vld[j-1];
      assign rem_in  = rem[j-1];
      assign den_in  = den[j-1];
      assign quot_in = quot[j-1];
      assign sat_in  = sat[j-1];
      assign side_in = side[j-1];
    end

    assign trial = CW'(den_in) << (FRAC - 1 - j);
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= ge ? (rem_in - trial) : rem_in;
        den[j]  <= den_in;
        quot[j] <= {quot_in[FRAC-2:0], ge};
        sat[j]  <= sat_in;
        side[j] <= side_in;
      end
    end
  end

  assign out_valid = vld[FRAC-1];
  assign out_quot  = quot[FRAC-1];
  assign out_sat   = sat[FRAC-1];
  assign out_side  = side[FRAC-1];

endmodule

>>> hdl/stick_deadzone_normalizer_unit.sv
// Top level of the stick deadzone normaliser: config registers, pipeline glue.
// Depends on sdn_pkg, sdn_isqrt and sdn_div.
//
// Usage:
//  - Input channel in_valid/in_ready carries one sample per request: raw_x,
//    raw_y, stick_select and source_kind. Output channel out_valid/out_ready
//    carries out_x, out_y (Q1.15) and in_deadzone.
//  - Config port: cfg_we writes cfg_wdata into register cfg_addr on the same
//    edge (0 left dz, 1 right dz, 2 axial threshold, 3 axial full scale).
//    Write only while the pipeline is empty.
//  - The pipeline has three entry stages, one square root stage per root bit,
//    two set-up stages, a 16-stage divider (overflow check plus 15 quotient
//    bits) and the output register.
//  - Throughput is one request per cycle unless the receiver stalls; every stage advances together.
//  - When the receiver stalls with a result held, the whole pipeline holds
//    and in_ready falls; nothing is dropped or duplicated.
//  - Reset clears all valid bits and loads register defaults.
module stick_deadzone_normalizer_unit #(
  parameter int AXIS_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               raw_x,
  input  logic signed [15:0]               raw_y,
  input  logic                             stick_select,
  input  logic [1:0]                       source_kind,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               out_x,
  output logic signed [15:0]               out_y,
  output logic                             in_deadzone,
  input  logic                             cfg_we,
  input  logic [sdn_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sdn_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sdn_pkg::*;

  localparam int AB  = AXIS_BITS;
  localparam int PW  = 2 * AB - 1;
  localparam int DW  = (2 * AB - 2 > FS_W) ? 2 * AB - 2 : FS_W;
  localparam int NW  = PW + FRAC;
  localparam logic [15:0] RAW_MAX = 16'((1 << (AB - 1)) - 1);

  typedef struct packed {
    logic [AB-1:0] ax;
    logic [AB-1:0] ay;
    logic          negx;
    logic          negy;
    logic [1:0]    kind;
    logic          sel;
    logic          zx;
    logic          zy;
  } side_t;

  typedef struct packed {
    logic       negx;
    logic       zx;
    logic       dz_hit;
    logic [1:0] kind;
  } xtail_t;

  typedef struct packed {
    logic negy;
    logic zy;
  } ytail_t;

  logic en;

  logic [DZ_W-1:0]  left_dz;
  logic [DZ_W-1:0]  right_dz;
  logic [THR_W-1:0] ax_thr;
  logic [FS_W-1:0]  ax_fs;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= LEFT_DZ_RST;
      right_dz <= RIGHT_DZ_RST;
      ax_thr   <= AX_THR_RST;
      ax_fs    <= AX_FS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LEFT_DZ:  left_dz  <= cfg_wdata;
        REG_RIGHT_DZ: right_dz <= cfg_wdata;
        REG_AX_THR:   ax_thr   <= cfg_wdata[THR_W-1:0];
        REG_AX_FS:    ax_fs    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage A: decode
  logic [AB-1:0] xr, yr, ax_in, ay_in;
  logic          a_vld;
  side_t         a_side, side_in;

  assign xr    = raw_x[AB-1:0];
  assign yr    = raw_y[AB-1:0];
  assign ax_in = xr[AB-1] ? (~xr + 1'b1) : xr;
  assign ay_in = yr[AB-1] ? (~yr + 1'b1) : yr;

  always_comb begin
    side_in.ax   = ax_in;
    side_in.ay   = ay_in;
    side_in.negx = xr[AB-1];
    side_in.negy = (source_kind == KIND_AXIAL) ? (!yr[AB-1] && (yr != '0)) : yr[AB-1];
    side_in.kind = source_kind;
    side_in.sel  = stick_select;
    side_in.zx   = 16'(ax_in) < 16'(ax_thr);
    side_in.zy   = 16'(ay_in) < 16'(ax_thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= side_in;
    end
  end

  // stage B: squares, stage C: sum
  logic            b_vld, c_vld;
  logic [2*AB-1:0] b_sqx, b_sqy, c_sum;
  side_t           b_side, c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sqx  <= a_side.ax * a_side.ax;
      b_sqy  <= a_side.ay * a_side.ay;
      b_side <= a_side;
      c_sum  <= b_sqx + b_sqy;
      c_side <= b_side;
    end
  end

  logic          s_vld;
  logic [AB-1:0] s_root;
  side_t         s_side;

  sdn_isqrt #(
    .AB   (AB),
    .SB_W ($bits(side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_vld),
    .in_rad    (c_sum),
    .in_side   (c_side),
    .out_valid (s_vld),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  // stage D: deadzone test and clamp
  logic [DZ_W-1:0] dz_sel;
  logic [AB-2:0]   magc;
  logic            d_vld, d_inside;
  logic [AB-2:0]   d_magc, d_diff, d_rdiff;
  side_t           d_side;

  assign dz_sel = s_side.sel ? right_dz : left_dz;
  assign magc   = (16'(s_root) > RAW_MAX) ? RAW_MAX[AB-2:0] : s_root[AB-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_inside <= (16'(dz_sel) >= RAW_MAX) || (16'(s_root) <= 16'(dz_sel));
      d_magc   <= magc;
      d_diff   <= magc - dz_sel[AB-2:0];
      d_rdiff  <= RAW_MAX[AB-2:0] - dz_sel[AB-2:0];
      d_side   <= s_side;
    end
  end

  // stage E: numerators and denominator
  logic            e_vld;
  logic [PW-1:0]   e_px, e_py;
  logic [DW-1:0]   e_den;
  logic [2*AB-3:0] rden;
  logic [FS_W-1:0] fs_eff;
  xtail_t          e_xt;
  ytail_t          e_yt;
  logic            is_axial;

  assign rden     = d_magc * d_rdiff;
  assign fs_eff   = (ax_fs == '0) ? FS_W'(1) : ax_fs;
  assign is_axial = d_side.kind == KIND_AXIAL;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_px        <= is_axial ? PW'(d_side.ax) : PW'(d_side.ax) * PW'(d_diff);
      e_py        <= is_axial ? PW'(d_side.ay) : PW'(d_side.ay) * PW'(d_diff);
      e_den       <= is_axial ? DW'(fs_eff) : DW'(rden);
      e_xt.negx   <= d_side.negx;
      e_xt.zx     <= d_side.zx;
      e_xt.dz_hit <= d_inside;
      e_xt.kind   <= d_side.kind;
      e_yt.negy   <= d_side.negy;
      e_yt.zy     <= d_side.zy;
    end
  end

  logic            dvx_vld, dvy_vld, dvx_sat, dvy_sat;
  logic [FRAC-1:0] dvx_q, dvy_q;
  xtail_t          f_xt;
  ytail_t          f_yt;

  sdn_div #(
    .NW   (NW),
    .DW   (DW),
    .SB_W ($bits(xtail_t))
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_vld),
    .in_num    ({e_px, {FRAC{1'b0}}}),
    .in_den    (e_den),
    .in_side   (e_xt),
    .out_valid (dvx_vld),
    .out_quot  (dvx_q),
    .out_sat   (dvx_sat),
    .out_side  (f_xt)
  );

  sdn_div #(
    .NW   (NW),
    .DW   (DW),
    .SB_W ($bits(ytail_t))
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_vld),
    .in_num    ({e_py, {FRAC{1'b0}}}),
    .in_den    (e_den),
    .in_side   (e_yt),
    .out_valid (dvy_vld),
    .out_quot  (dvy_q),
    .out_sat   (dvy_sat),
    .out_side  (f_yt)
  );

  // output register
  logic [15:0] ox_next, oy_next;
  logic        dz_next;

  always_comb begin
    ox_next = '0;
    oy_next = '0;
    dz_next = 1'b0;
    case (f_xt.kind)
      KIND_RADIAL: begin
        if (f_xt.dz_hit) begin
          dz_next = 1'b1;
        end else begin
          ox_next = sat_pack(f_xt.negx, dvx_sat, dvx_q);
          oy_next = sat_pack(f_yt.negy, dvy_sat, dvy_q);
        end
      end
      KIND_AXIAL: begin
        ox_next = f_xt.zx ? 16'd0 : sat_pack(f_xt.negx, dvx_sat, dvx_q);
        oy_next = f_yt.zy ? 16'd0 : sat_pack(f_yt.negy, dvy_sat, dvy_q);
        dz_next = f_xt.zx && f_yt.zy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvx_vld && dvy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x       <= ox_next;
      out_y       <= oy_next;
      in_deadzone <= dz_next;
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_deadzone |-> out_x == 16'sd0 && out_y == 16'sd0)
    else $error("deadzone result not zero");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_x != 16'sh8000 && out_y != 16'sh8000)
    else $error("output beyond saturation limit");

  a_div_lock: assert property (@(posedge clk) disable iff (rst)
    dvx_vld == dvy_vld)
    else $error("divider lanes out of step");

  a_diff_nz: assert property (@(posedge clk) disable iff (rst)
    d_vld && !d_inside && d_side.kind == KIND_RADIAL |-> d_diff != '0)
    else $error("radial request outside deadzone with zero excess");

endmodule
